### rtl/fps_pkg.sv
// Shared types and constants for the farthest point sampler.
package fps_pkg;

    localparam int unsigned DEF_MAX_POINTS   = 1024;
    localparam int unsigned DEF_MAX_FEATURES = 64;
    localparam int unsigned DEF_FEATURE_BITS = 16;

    localparam int unsigned DIST_W = 39;
    localparam int unsigned OUT_W  = 38;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_FORCE  = 2'd1;
    localparam logic [1:0] KIND_SELECT = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_TOO_MANY = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [1:0] CFG_POINTS   = 2'd0;
    localparam logic [1:0] CFG_FEATURES = 2'd1;
    localparam logic [1:0] CFG_TARGET   = 2'd2;
    localparam logic [1:0] CFG_FIRST    = 2'd3;

endpackage

### rtl/fps_dist_acc.sv
// Saturating squared-difference accumulator for one point pair.
module fps_dist_acc #(
    parameter int unsigned FEATURE_BITS = fps_pkg::DEF_FEATURE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_clear,
    input  logic                      i_en,
    input  logic [FEATURE_BITS-1:0]   i_a,
    input  logic [FEATURE_BITS-1:0]   i_b,
    output logic [fps_pkg::DIST_W-1:0] o_sum
);
    import fps_pkg::*;

    localparam int unsigned DW = FEATURE_BITS + 1;
    localparam int unsigned PW = 2 * DW;
    localparam logic [DIST_W-1:0] CAP = {DIST_W{1'b1}};

    logic signed [DW-1:0] w_diff;
    logic [DW-1:0]        w_abs;
    logic [PW-1:0]        r_prod;
    logic                 r_big;
    logic                 r_pv;
    logic [DIST_W-1:0]    r_sum;
    logic [DIST_W:0]      w_add;
    logic                 w_ovf;

    assign w_diff = DW'($signed(i_a)) - DW'($signed(i_b));
    assign w_abs  = w_diff[DW-1] ? DW'(-w_diff) : DW'(w_diff);

    // Square in one stage, accumulate in the next.
    always_ff @(posedge i_clk) begin
        r_pv <= i_en && !i_clear;
        if (i_en) begin
            r_prod <= PW'(w_abs) * PW'(w_abs);
            r_big  <= (DW > 20) ? (64'(w_abs) >= 64'(1 << 20)) : 1'b0;
        end
    end

    always_comb begin
        w_ovf = 1'b0;
        if (PW > DIST_W) begin
            w_ovf = (r_prod >> DIST_W) != '0;
        end
        w_add = (DIST_W+1)'(r_sum) + (DIST_W+1)'(r_prod[PW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_sum <= '0;
        end else if (r_pv) begin
            if (r_big || w_ovf || w_add[DIST_W] || w_add[DIST_W-1:0] == CAP) begin
                r_sum <= CAP;
            end else begin
                r_sum <= w_add[DIST_W-1:0];
            end
        end
    end

    assign o_sum = r_sum;
endmodule

### rtl/farthest_point_sampler.sv
// Top level of the farthest point sampler.
// One item is in flight at a time: ready stays low from acceptance until the
// result beat is taken. Loads and refused items answer from S_RD through
// S_OUT; reads also pass S_RD2 and S_CP. A select sweeps every point in use.
// For each point it streams that point's features out of the feature memory
// against the chosen point's features, one feature a cycle, and then updates
// the point's minimum distance. The single read port of the feature memory
// and the pipeline into the accumulator set the pace of each point. Before
// the sweep the chosen point's features are copied into a small buffer. A
// select without a given point, other than the first, first scans all
// minimum distances in use for the largest.
module farthest_point_sampler #(
    parameter int unsigned MAX_POINTS   = fps_pkg::DEF_MAX_POINTS,
    parameter int unsigned MAX_FEATURES = fps_pkg::DEF_MAX_FEATURES,
    parameter int unsigned FEATURE_BITS = fps_pkg::DEF_FEATURE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [9:0]  i_point_index,
    input  logic [5:0]  i_feature_index,
    input  logic [15:0] i_feature_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [9:0]  o_selected_index,
    output logic [37:0] o_distance,
    output logic [10:0] o_rank
);
    import fps_pkg::*;

    localparam int unsigned PB = $clog2(MAX_POINTS);
    localparam int unsigned FB = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int unsigned PC = $clog2(MAX_POINTS + 1);
    localparam int unsigned FC = $clog2(MAX_FEATURES + 1);
    localparam int unsigned AW = PB + FB;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RD2, S_MAX0, S_MAX, S_CP, S_SW_START, S_SW_FEAT, S_SW_WAIT1,
        S_SW_WAIT2, S_SW_MD, S_SW_UPD, S_OUT
    } t_state;

    t_state r_state;

    logic [10:0] r_point_count, r_feature_count, r_target_count;
    logic [9:0]  r_first_point;
    logic [PC-1:0] r_sel_cnt;

    logic [FEATURE_BITS-1:0] r_fmem [MAX_POINTS*MAX_FEATURES];
    logic [DIST_W-1:0]       r_dmem [MAX_POINTS];
    logic [FEATURE_BITS-1:0] r_cbuf [MAX_FEATURES];

    logic [AW-1:0] r_frd_addr;
    logic          r_frd_en;
    logic [FEATURE_BITS-1:0] r_frd;
    logic [PB-1:0] r_drd_addr;
    logic [DIST_W-1:0] r_drd;
    logic          r_dwe;
    logic [PB-1:0] r_dwa;
    logic [DIST_W-1:0] r_dwd;
    logic          r_fwe;
    logic [AW-1:0] r_fwa;
    logic [FEATURE_BITS-1:0] r_fwd;

    // Effective counts.
    logic [PC-1:0] w_n;
    logic [FC-1:0] w_nf;
    logic [PC-1:0] w_target;
    logic          w_tgt_big;
    always_comb begin
        if (r_point_count == 11'd0) begin
            w_n = PC'(1);
        end else if (32'(r_point_count) > MAX_POINTS) begin
            w_n = PC'(MAX_POINTS);
        end else begin
            w_n = PC'(r_point_count);
        end
        if (r_feature_count == 11'd0) begin
            w_nf = FC'(1);
        end else if (32'(r_feature_count) > MAX_FEATURES) begin
            w_nf = FC'(MAX_FEATURES);
        end else begin
            w_nf = FC'(r_feature_count);
        end
        w_tgt_big = (r_target_count != 11'd0) && (32'(r_target_count) > 32'(w_n));
        w_target  = (r_target_count == 11'd0) ? w_n : PC'(r_target_count);
    end

    // Item registers.
    logic [1:0]  r_kind;
    logic [9:0]  r_pidx;
    logic [5:0]  r_fidx;
    logic [15:0] r_fval;
    logic [PB-1:0] r_pick;
    logic [PB-1:0] r_j, r_best;
    logic [DIST_W-1:0] r_best_d, r_pick_d;
    logic [FC-1:0] r_f;
    logic          r_first_sel;

    logic          w_acc_clear, w_acc_en;
    logic [DIST_W-1:0] w_sum;
    logic [FEATURE_BITS-1:0] r_cb_rd;

    fps_dist_acc #(.FEATURE_BITS(FEATURE_BITS)) u_acc (
        .i_clk   (i_clk),
        .i_clear (w_acc_clear),
        .i_en    (w_acc_en),
        .i_a     (r_frd),
        .i_b     (r_cb_rd),
        .o_sum   (w_sum)
    );

    // Memories.
    always_ff @(posedge i_clk) begin
        if (r_fwe) begin
            r_fmem[r_fwa] <= r_fwd;
        end
        r_frd <= r_fmem[r_frd_addr];
        if (r_dwe) begin
            r_dmem[r_dwa] <= r_dwd;
        end
        r_drd <= r_dmem[r_drd_addr];
    end

    logic r_cp_we;
    logic [FB-1:0] r_cp_wa, r_cb_ra;
    always_ff @(posedge i_clk) begin
        if (r_cp_we) begin
            r_cbuf[r_cp_wa] <= r_frd;
        end
        r_cb_rd <= r_cbuf[r_cb_ra];
    end

    // Feature stream valid, delayed to match memory latency.
    logic r_fv;
    assign w_acc_en    = r_fv;
    assign w_acc_clear = (r_state == S_SW_START);

    assign o_ready = (r_state == S_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_point_count   <= 11'd1024;
            r_feature_count <= 11'd64;
            r_target_count  <= 11'd0;
            r_first_point   <= 10'd0;
            r_sel_cnt       <= '0;
            o_valid         <= 1'b0;
            r_fwe           <= 1'b0;
            r_dwe           <= 1'b0;
            r_cp_we         <= 1'b0;
            r_fv            <= 1'b0;
            r_frd_en        <= 1'b0;
        end else begin
            r_fwe   <= 1'b0;
            r_dwe   <= 1'b0;
            r_cp_we <= 1'b0;
            r_fv    <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POINTS:   r_point_count   <= i_cfg_data;
                    CFG_FEATURES: r_feature_count <= {4'd0, i_cfg_data[6:0]};
                    CFG_TARGET:   r_target_count  <= i_cfg_data;
                    CFG_FIRST:    r_first_point   <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_kind <= i_kind;
                        r_pidx <= i_point_index;
                        r_fidx <= i_feature_index;
                        r_fval <= i_feature_value;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    o_selected_index <= '0;
                    o_distance       <= '0;
                    o_status         <= ST_OK;
                    r_state          <= S_OUT;
                    case (r_kind)
                        KIND_LOAD: begin
                            if (32'(r_pidx) >= 32'(w_n) || 32'(r_fidx) >= 32'(w_nf)) begin
                                o_status <= ST_RANGE;
                            end else begin
                                r_fwe <= 1'b1;
                                r_fwa <= AW'(32'(r_pidx) * MAX_FEATURES + 32'(r_fidx));
                                r_fwd <= FEATURE_BITS'($signed(r_fval));
                            end
                        end
                        KIND_READ: begin
                            if (32'(r_pidx) >= 32'(w_n)) begin
                                o_status <= ST_RANGE;
                            end else begin
                                r_drd_addr <= PB'(r_pidx);
                                r_state    <= S_RD2;
                            end
                        end
                        default: begin
                            if (w_tgt_big) begin
                                o_status <= ST_TOO_MANY;
                            end else if (r_sel_cnt >= w_target) begin
                                o_status <= ST_DONE;
                            end else if (r_kind == KIND_FORCE
                                         && 32'(r_pidx) >= 32'(w_n)) begin
                                o_status <= ST_RANGE;
                            end else if (r_kind == KIND_SELECT && r_sel_cnt == '0
                                         && 32'(r_first_point) >= 32'(w_n)) begin
                                o_status <= ST_RANGE;
                            end else begin
                                r_first_sel <= (r_sel_cnt == '0);
                                if (r_kind == KIND_FORCE) begin
                                    r_pick <= PB'(r_pidx);
                                    r_drd_addr <= PB'(r_pidx);
                                    r_state <= S_RD2;
                                end else if (r_sel_cnt == '0) begin
                                    r_pick <= PB'(r_first_point);
                                    r_state <= S_RD2;
                                end else begin
                                    // Scan the minimum distances in use for the largest.
                                    r_drd_addr <= '0;
                                    r_state    <= S_MAX0;
                                end
                                r_f <= '0;
                            end
                        end
                    endcase
                end
                S_RD2: begin
                    // One wait for the distance read.
                    if (r_kind == KIND_READ) begin
                        r_state <= S_CP;
                        r_f <= '0;
                    end else begin
                        r_state <= S_CP;
                        r_f <= '0;
                    end
                end
                S_MAX0: begin
                    r_drd_addr <= PB'(1);
                    r_j        <= '0;
                    r_best     <= '0;
                    r_best_d   <= '0;
                    r_state    <= S_MAX;
                end
                S_MAX: begin
                    logic v_take;
                    // Strictly larger only: the lowest index wins a tie.
                    v_take = (r_j == '0) || (r_drd > r_best_d);
                    if (v_take) begin
                        r_best   <= r_j;
                        r_best_d <= r_drd;
                    end
                    r_drd_addr <= r_drd_addr + PB'(1);
                    r_j        <= r_j + PB'(1);
                    if (32'(r_j) + 1 >= 32'(w_n)) begin
                        r_pick   <= v_take ? r_j : r_best;
                        r_pick_d <= v_take ? r_drd : r_best_d;
                        r_f      <= '0;
                        r_state  <= S_CP;
                    end
                end
                S_CP: begin
                    if (r_kind == KIND_READ) begin
                        o_distance <= (r_drd > DIST_W'({OUT_W{1'b1}}))
                                      ? {OUT_W{1'b1}} : r_drd[OUT_W-1:0];
                        r_state <= S_OUT;
                    end else begin
                        if (r_kind == KIND_FORCE && r_f == '0 && !r_cp_we) begin
                            r_pick_d <= r_drd;
                        end
                        // Copy the chosen point's features, one a cycle.
                        if (32'(r_f) < 32'(w_nf)) begin
                            r_frd_addr <= AW'(32'(r_pick) * MAX_FEATURES + 32'(r_f));
                            r_f <= r_f + FC'(1);
                        end
                        r_cp_we <= r_frd_en;
                        r_cp_wa <= FB'(r_f - FC'(1));
                        r_frd_en <= (32'(r_f) < 32'(w_nf));
                        if (32'(r_f) >= 32'(w_nf) && !r_frd_en) begin
                            r_j       <= '0;
                            r_state   <= S_SW_START;
                        end
                    end
                end
                S_SW_START: begin
                    r_f <= '0;
                    r_frd_en <= 1'b0;
                    r_drd_addr <= r_j;
                    r_state <= S_SW_FEAT;
                end
                S_SW_FEAT: begin
                    // Stream features of point j against the buffer.
                    r_frd_addr <= AW'(32'(r_j) * MAX_FEATURES + 32'(r_f));
                    r_cb_ra    <= FB'(r_f);
                    r_frd_en   <= 1'b1;
                    r_fv       <= r_frd_en;
                    r_f        <= r_f + FC'(1);
                    if (32'(r_f) + 1 >= 32'(w_nf)) begin
                        r_state <= S_SW_WAIT1;
                    end
                end
                S_SW_WAIT1: begin
                    r_fv     <= 1'b1;
                    r_frd_en <= 1'b0;
                    r_state  <= S_SW_WAIT2;
                end
                S_SW_WAIT2: begin
                    r_state <= S_SW_MD;
                end
                S_SW_MD: begin
                    r_state <= S_SW_UPD;
                end
                S_SW_UPD: begin
                    logic [DIST_W-1:0] v_nd;
                    v_nd = (r_first_sel || w_sum < r_drd) ? w_sum : r_drd;
                    r_dwe <= 1'b1;
                    r_dwa <= r_j;
                    r_dwd <= v_nd;
                    if (32'(r_j) + 1 >= 32'(w_n)) begin
                        r_sel_cnt <= r_sel_cnt + PC'(1);
                        o_selected_index <= 10'(r_pick);
                        o_distance <= r_first_sel ? '0
                                      : (r_pick_d > DIST_W'({OUT_W{1'b1}}))
                                      ? {OUT_W{1'b1}} : r_pick_d[OUT_W-1:0];
                        o_status <= (r_sel_cnt + PC'(1) >= w_target) ? ST_DONE : ST_OK;
                        r_state <= S_OUT;
                    end else begin
                        r_j <= r_j + PB'(1);
                        r_state <= S_SW_START;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_rank  <= 11'(r_sel_cnt);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### verif/testbench.sv
// Self-checking testbench for the farthest point sampler: directed and random items.
`timescale 1ns / 100ps

module testbench;
    import fps_pkg::*;

    localparam longint unsigned DIST_CAP = (64'd1 << DIST_W) - 1;
    localparam longint unsigned OUT_CAP  = (64'd1 << OUT_W) - 1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  pidx;
        logic [5:0]  fidx;
        logic [15:0] value;
    } t_sample_op;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  sel;
        logic [37:0] distance;
        logic [10:0] rank;
    } t_pick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = '0;
    logic [9:0]  i_point_index = '0;
    logic [5:0]  i_feature_index = '0;
    logic [15:0] i_feature_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [9:0]  o_selected_index;
    logic [37:0] o_distance;
    logic [10:0] o_rank;

    farthest_point_sampler dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the sampler state
    logic signed [15:0] feat_shadow [0:65535];
    bit                 feat_loaded [0:65535];
    logic [38:0]        min_dist_shadow [0:1023];
    bit                 min_dist_set [0:1023];
    int unsigned        pts_reg = 1024, feats_reg = 64, target_reg = 0, first_reg = 0;
    int unsigned        picked = 0;

    t_sample_op  op_queue [$];
    t_pick       pick_queue [$];
    int          errors = 0;
    int          rand_ops = 0;
    bit          hold_tx = 1'b0;
    logic        in_beat = 1'b0, out_beat = 1'b0;
    int          tx_gap = 0, rx_wait = 0, burst_left = 0;

    function automatic int unsigned pts_in_use();
        return (pts_reg < 1) ? 1 : (pts_reg > 1024 ? 1024 : pts_reg);
    endfunction

    function automatic int unsigned feats_in_use();
        return (feats_reg < 1) ? 1 : (feats_reg > 64 ? 64 : feats_reg);
    endfunction

    function automatic longint unsigned pair_dist(int unsigned a, int unsigned b,
                                                  int unsigned nf);
        longint          d;
        longint unsigned acc;
        acc = 0;
        for (int unsigned f = 0; f < nf; f++) begin
            d = longint'(feat_shadow[a*64+f]) - longint'(feat_shadow[b*64+f]);
            acc += longint'(d * d);
            if (acc > DIST_CAP) return DIST_CAP;
        end
        return acc;
    endfunction

    task automatic predict_pick(input t_sample_op op, output t_pick r);
        int unsigned     n, nf, tgt, p;
        bit              ok;
        longint unsigned pick_dist, d;
        n = pts_in_use();
        nf = feats_in_use();
        tgt = (target_reg == 0) ? n : target_reg;
        r = '0;
        pick_dist = 0;
        if (op.kind == KIND_LOAD) begin
            if (op.pidx >= n || op.fidx >= nf) begin
                r.status = ST_RANGE;
            end else begin
                feat_shadow[op.pidx*64+op.fidx] = op.value;
                feat_loaded[op.pidx*64+op.fidx] = 1'b1;
            end
        end else if (op.kind == KIND_READ) begin
            if (op.pidx >= n) r.status = ST_RANGE;
            else pick_dist = 64'(min_dist_shadow[op.pidx]);
        end else if (tgt > n) begin
            r.status = ST_TOO_MANY;
        end else if (picked >= tgt) begin
            r.status = ST_DONE;
        end else begin
            ok = 1'b1;
            if (op.kind == KIND_FORCE) begin
                p = 32'(op.pidx);
                ok = (p < n);
            end else if (picked == 0) begin
                p = first_reg;
                ok = (p < n);
            end else begin
                p = 0;
                for (int unsigned j = 1; j < n; j++)
                    if (min_dist_shadow[j] > min_dist_shadow[p]) p = j;
            end
            if (!ok) begin
                r.status = ST_RANGE;
            end else begin
                pick_dist = (picked == 0) ? 64'd0 : 64'(min_dist_shadow[p]);
                r.sel = 10'(p);
                for (int unsigned j = 0; j < n; j++) begin
                    d = pair_dist(j, p, nf);
                    if (picked == 0 || d < min_dist_shadow[j]) min_dist_shadow[j] = 39'(d);
                    min_dist_set[j] = 1'b1;
                end
                picked++;
                if (picked >= tgt) r.status = ST_DONE;
            end
        end
        r.distance = 38'((pick_dist > OUT_CAP) ? OUT_CAP : pick_dist);
        r.rank = 11'(picked);
    endtask

    task automatic push_op(input logic [1:0] kind, input int unsigned pidx,
                           input int unsigned fidx, input logic [15:0] value);
        t_sample_op op;
        t_pick      r;
        op.kind = kind;
        op.pidx = 10'(pidx);
        op.fidx = 6'(fidx);
        op.value = value;
        predict_pick(op, r);
        op_queue.push_back(op);
        pick_queue.push_back(r);
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic wait_idle();
        while (op_queue.size() != 0 || pick_queue.size() != 0 || i_valid)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_regs(input int unsigned n, input int unsigned nf,
                            input int unsigned tgt, input int unsigned first);
        logic [10:0] vals [4];
        wait_idle();
        vals[0] = 11'(n);
        vals[1] = 11'(nf);
        vals[2] = 11'(tgt);
        vals[3] = 11'(first);
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= i[1:0];
            i_cfg_data <= vals[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pts_reg = n & 11'h7ff;
        feats_reg = nf & 7'h7f;
        target_reg = tgt & 11'h7ff;
        first_reg = first & 10'h3ff;
    endtask

    // Load every feature in the active region that was never written
    task automatic fill_features();
        for (int unsigned p = 0; p < pts_in_use(); p++)
            for (int unsigned f = 0; f < feats_in_use(); f++)
                if (!feat_loaded[p*64+f]) push_op(KIND_LOAD, p, f, rand_value());
    endtask

    // A select may sweep only when every minimum distance in use is defined
    function automatic bit select_safe();
        int unsigned n, tgt;
        n = pts_in_use();
        tgt = (target_reg == 0) ? n : target_reg;
        if (picked == 0 || tgt > n || picked >= tgt) return 1'b1;
        for (int unsigned j = 0; j < n; j++)
            if (!min_dist_set[j]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic rand_op();
        int unsigned n, nf, w, p;
        n = pts_in_use();
        nf = feats_in_use();
        w = $urandom_range(0, 99);
        if (w < 35) begin
            if ($urandom_range(0, 9) == 0)
                push_op(KIND_LOAD, $urandom_range(0, n - 1), $urandom_range(nf, 63),
                        rand_value());
            else if ($urandom_range(0, 9) == 0 && n < 1024)
                push_op(KIND_LOAD, $urandom_range(n, 1023), $urandom_range(0, 63),
                        rand_value());
            else
                push_op(KIND_LOAD, $urandom_range(0, n - 1), $urandom_range(0, nf - 1),
                        rand_value());
        end else if (w < 55) begin
            p = $urandom_range(0, n - 1);
            if ($urandom_range(0, 9) == 0 || !min_dist_set[p])
                p = (n < 1024) ? $urandom_range(n, 1023) : 0;
            if (p < n && !min_dist_set[p]) p = 0;
            push_op(KIND_READ, p, $urandom_range(0, 63), 16'($urandom()));
        end else if (select_safe()) begin
            if (w < 70)
                push_op(KIND_FORCE, ($urandom_range(0, 9) == 0 && n < 1024) ?
                        $urandom_range(n, 1023) : $urandom_range(0, n - 1),
                        $urandom_range(0, 63), 16'($urandom()));
            else
                push_op(KIND_SELECT, $urandom_range(0, 1023), $urandom_range(0, 63),
                        16'($urandom()));
        end else begin
            push_op(KIND_LOAD, $urandom_range(0, n - 1), $urandom_range(0, nf - 1),
                    rand_value());
        end
        rand_ops++;
    endtask

    initial begin
        int unsigned n, nf, tgt, hi, lo, cnt;
        bit          paused;
        paused = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Nothing chosen yet: refused items only
        set_regs(4, 2, 0, 1023);
        push_op(KIND_LOAD, 1023, 0, 16'h7fff);
        push_op(KIND_LOAD, 0, 63, 16'h8000);
        push_op(KIND_SELECT, 0, 0, 16'h0000);
        push_op(KIND_FORCE, 1023, 0, 16'h0000);
        push_op(KIND_READ, 1023, 63, 16'hffff);

        // First selection fixes the widest point range swept later
        set_regs(40, 2, 0, 39);
        fill_features();
        push_op(KIND_SELECT, 0, 0, 16'h0000);
        push_op(KIND_FORCE, 1023, 0, 16'h0000);
        push_op(KIND_FORCE, 0, 0, 16'h0000);
        push_op(KIND_SELECT, 0, 0, 16'h0000);
        push_op(KIND_READ, 0, 0, 16'h0000);
        push_op(KIND_READ, 39, 0, 16'h0000);
        push_op(KIND_READ, 20, 0, 16'h0000);

        set_regs(4, 1, 5, 39);
        push_op(KIND_SELECT, 0, 0, 16'h0000);
        set_regs(40, 1, 5, 39);
        push_op(KIND_SELECT, 0, 0, 16'h0000);
        push_op(KIND_SELECT, 0, 0, 16'h0000);
        push_op(KIND_SELECT, 0, 0, 16'h0000);

        set_regs(1024, 64, 1, 1023);
        push_op(KIND_SELECT, 0, 0, 16'h0000);
        push_op(KIND_FORCE, 5, 0, 16'h0000);
        push_op(KIND_LOAD, 1023, 63, 16'h8000);
        push_op(KIND_READ, 0, 0, 16'h0000);

        set_regs(1, 1, 0, 0);
        push_op(KIND_SELECT, 0, 0, 16'h0000);
        push_op(KIND_LOAD, 1, 0, 16'h1234);
        push_op(KIND_READ, 0, 0, 16'h0000);
        push_op(KIND_READ, 1, 0, 16'h0000);

        while (rand_ops < 150) begin
            lo = (picked + 4 > 40) ? 2 : picked + 4;
            n = $urandom_range(lo, 40);
            nf = $urandom_range(1, 4);
            case ($urandom_range(0, 9))
                0: tgt = 0;
                1: tgt = $urandom_range(n + 1, 1024);
                default: begin
                    hi = (n < picked + 10) ? n : picked + 10;
                    tgt = $urandom_range((picked + 1 < hi) ? picked + 1 : hi, hi);
                end
            endcase
            set_regs(n, nf, tgt, $urandom_range(0, 1023));
            fill_features();
            cnt = $urandom_range(25, 40);
            for (int i = 0; i < cnt; i++) begin
                rand_op();
                // Hold the sender until the block has drained once
                if (!paused && rand_ops == 75) begin
                    paused = 1'b1;
                    hold_tx = 1'b1;
                    while (pick_queue.size() > op_queue.size() || i_valid) @(negedge i_clk);
                    hold_tx = 1'b0;
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pick_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report(input string what, input longint unsigned got,
                          input longint unsigned want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Sample handshakes and check results against the oldest expectation
    always @(posedge i_clk) begin
        t_pick want;
        in_beat <= i_rst_n && i_valid && o_ready;
        out_beat <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (pick_queue.size() == 0) begin
                report("unexpected beat, status", o_status, 0);
            end else begin
                want = pick_queue.pop_front();
                if (o_status !== want.status) report("status", o_status, want.status);
                if (o_selected_index !== want.sel)
                    report("selected_index", o_selected_index, want.sel);
                if (o_distance !== want.distance)
                    report("distance", o_distance, want.distance);
                if (o_rank !== want.rank) report("rank", o_rank, want.rank);
            end
        end
    end

    // Driver: present the next pending item after a random gap
    always @(negedge i_clk) begin
        t_sample_op op;
        if (i_rst_n) begin
            if (in_beat) begin
                if (burst_left > 0) begin
                    burst_left--;
                    tx_gap = 0;
                end else begin
                    if ($urandom_range(0, 15) == 0) burst_left = 20;
                    tx_gap = $urandom_range(0, 8);
                end
            end
            if (!(i_valid && !in_beat)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (op_queue.size() != 0 && !hold_tx) begin
                    op = op_queue.pop_front();
                    i_kind <= op.kind;
                    i_point_index <= op.pidx;
                    i_feature_index <= op.fidx;
                    i_feature_value <= op.value;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall a random number of cycles after each result beat
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_beat) rx_wait = $urandom_range(0, 8);
            else if (rx_wait > 0) rx_wait--;
            i_ready <= (rx_wait == 0);
        end
    end

endmodule
